@@ rtl/pfr_pkg.sv @@
// Package for the PCM frame resampler: widths, codes, state types and the
// control structs shared by the top level and the blend unit. No dependencies.
`timescale 1ns / 1ps

package pfr_pkg;

   localparam int FRAC_BITS   = 10;
   localparam int SAMPLE_W    = 16;
   localparam int FRAME_W     = 32;
   localparam int RATIO_W     = 24;
   localparam int COUNT_W     = 17;
   localparam int PHASE_W     = 32;
   localparam int MODE_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [PHASE_W-1:0] PHASE_STEP   = PHASE_W'(1) << FRAC_BITS;
   localparam logic [FRAME_W-1:0] SIGN_FLIP    = 32'h8000_8000;
   localparam logic [RATIO_W-1:0] RATIO_RESET  = 24'd1024;
   localparam logic [COUNT_W-1:0] BLOCK_RESET  = 17'd2048;

   typedef enum logic [MODE_W-1:0] {
      MODE_START  = 3'd0,
      MODE_RESUME = 3'd1,
      MODE_PAUSE  = 3'd2,
      MODE_FRAME  = 3'd3,
      MODE_TICK   = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RATE_RATIO   = 3'd0,
      REG_SIXTEEN_BIT  = 3'd1,
      REG_STEREO       = 3'd2,
      REG_SIGNED_DATA  = 3'd3,
      REG_AUTO_INIT    = 3'd4,
      REG_BLOCK_FRAMES = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_LEFT,
      ST_RIGHT,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_MUL,
      U_ABS,
      U_DIV,
      U_DONE
   } unit_state_type;

   typedef struct packed {
      logic                       start;
      logic signed [SAMPLE_W-1:0] a;
      logic signed [SAMPLE_W-1:0] b;
   } blend_cmd_type;

   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] q;
   } blend_rsp_type;

endpackage

@@ rtl/pfr_req_if.sv @@
// Input channel of the PCM frame resampler: valid/ready plus mode and raw word.
// Depends on pfr_pkg for field widths.
`timescale 1ns / 1ps

interface pfr_req_if import pfr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [FRAME_W-1:0]  frame_data;

   modport source (output valid, output mode, output frame_data, input ready);
   modport sink   (input valid, input mode, input frame_data, output ready);
endinterface

@@ rtl/pfr_rsp_if.sv @@
// Result channel of the PCM frame resampler: valid/ready plus samples and flags.
// Depends on pfr_pkg for field widths.
`timescale 1ns / 1ps

interface pfr_rsp_if import pfr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left;
   logic signed [SAMPLE_W-1:0] right;
   logic                       sample_valid;
   logic                       fetch_request;
   logic                       block_irq;
   logic                       irq_is_16bit;
   logic                       running;

   modport source (output valid, output left, output right, output sample_valid,
                   output fetch_request, output block_irq, output irq_is_16bit,
                   output running, input ready);
   modport sink   (input valid, input left, input right, input sample_valid,
                   input fetch_request, input block_irq, input irq_is_16bit,
                   input running, output ready);
endinterface

@@ rtl/pfr_blend_unit.sv @@
// Shared blend unit: one signed multiplier and a restoring divider under a small
// sequencer compute trunc((a*(ratio-ph) + b*ph) / ratio) wrapped to 16 bits.
// Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_blend_unit import pfr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  blend_cmd_type       cmd,
   input  logic [RATIO_W-1:0]  ratio,
   input  logic [PHASE_W-1:0]  phase,
   output blend_rsp_type       rsp
);

   localparam int OPX_W     = SAMPLE_W + 2;
   localparam int OPY_W     = RATIO_W + 1;
   localparam int PROD_W    = OPX_W + OPY_W;
   localparam int HALF_W    = PHASE_W / 2;
   localparam int ACC_W     = 52;
   localparam int MAG_W     = 50;
   localparam int DIV_STEPS = MAG_W;
   localparam int CNT_W     = 6;

   localparam logic [CNT_W-1:0] STEP_BASE = CNT_W'(0);
   localparam logic [CNT_W-1:0] STEP_LOW  = CNT_W'(1);
   localparam logic [CNT_W-1:0] STEP_HIGH = CNT_W'(2);
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(3);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

   unit_state_type              state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic signed [SAMPLE_W-1:0]  a_ff, a_in;
   logic signed [SAMPLE_W-1:0]  b_ff, b_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        neg_ff, neg_in;
   logic [RATIO_W-1:0]          rem_ff, rem_in;
   logic [MAG_W-1:0]            dvd_ff, dvd_in;
   logic [SAMPLE_W-1:0]         quot_ff, quot_in;

   logic                        take_start;
   logic signed [OPX_W-1:0]     diff_ab;
   logic signed [OPX_W-1:0]     op_x;
   logic signed [OPY_W-1:0]     op_y;
   logic signed [ACC_W-1:0]     prod_ext;
   logic signed [ACC_W-1:0]     prod_hi;
   logic [ACC_W-1:0]            mag;
   logic [RATIO_W:0]            trial;
   logic [RATIO_W+1:0]          trial_diff;

   function automatic logic [OPX_W-1:0] cmd_b_ext(input logic signed [SAMPLE_W-1:0] v);
      return {{(OPX_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
   endfunction

   assign take_start = cmd.start && (state_ff == U_IDLE || state_ff == U_DONE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE:  if (cmd.start) state_in = U_MUL;
         U_MUL:   if (cnt_ff == STEP_LAST) state_in = U_ABS;
         U_ABS:   state_in = U_DIV;
         U_DIV:   if (cnt_ff == DIV_LAST) state_in = U_DONE;
         U_DONE:  state_in = cmd.start ? U_MUL : U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      rsp.done = (state_ff == U_DONE);
      rsp.q    = neg_ff ? $signed(SAMPLE_W'(~quot_ff + SAMPLE_W'(1))) : $signed(quot_ff);
   end

   // Datapath
   always_comb begin
      diff_ab  = $signed({cmd_b_ext(b_ff)}) - $signed({cmd_b_ext(a_ff)});
      op_x     = (cnt_ff == STEP_BASE) ? $signed(cmd_b_ext(a_ff)) : diff_ab;
      if (cnt_ff == STEP_BASE) begin
         op_y = $signed({1'b0, ratio});
      end else if (cnt_ff == STEP_LOW) begin
         op_y = $signed({{(OPY_W-HALF_W){1'b0}}, phase[HALF_W-1:0]});
      end else begin
         op_y = $signed({{(OPY_W-HALF_W){1'b0}}, phase[PHASE_W-1:HALF_W]});
      end
      prod_in  = op_x * op_y;
      prod_ext = $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
      prod_hi  = $signed({prod_ff[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}});
      mag      = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      trial      = {rem_ff, dvd_ff[MAG_W-1]};
      trial_diff = {1'b0, trial} - {2'b00, ratio};

      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;

      if (take_start) begin
         a_in   = cmd.a;
         b_in   = cmd.b;
         cnt_in = '0;
      end else begin
         case (state_ff)
            U_MUL: begin
               cnt_in = (cnt_ff == STEP_LAST) ? '0 : cnt_ff + CNT_W'(1);
               // product of the previous step lands in the accumulator
               if (cnt_ff == STEP_LOW) begin
                  acc_in = prod_ext;
               end else if (cnt_ff == STEP_HIGH) begin
                  acc_in = acc_ff + prod_ext;
               end else if (cnt_ff == STEP_LAST) begin
                  acc_in = acc_ff + prod_hi;
               end
            end
            U_ABS: begin
               neg_in = acc_ff[ACC_W-1];
               dvd_in = mag[MAG_W-1:0];
               rem_in = '0;
               cnt_in = '0;
            end
            U_DIV: begin
               cnt_in = cnt_ff + CNT_W'(1);
               dvd_in = {dvd_ff[MAG_W-2:0], 1'b0};
               if (!trial_diff[RATIO_W+1]) begin
                  rem_in  = trial_diff[RATIO_W-1:0];
                  quot_in = {quot_ff[SAMPLE_W-2:0], 1'b1};
               end else begin
                  rem_in  = trial[RATIO_W-1:0];
                  quot_in = {quot_ff[SAMPLE_W-2:0], 1'b0};
               end
            end
            default: cnt_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == U_IDLE || state_ff == U_DONE))
      else $error("blend unit started while busy");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done)
      else $error("blend unit done held for more than one cycle");

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_DIV) |-> (cnt_ff <= DIV_LAST))
      else $error("blend unit divide step count out of range");

endmodule

@@ rtl/pcm_frame_resampler.sv @@
// Non-tick items: result registered in the cycle after the transfer. Output
// tick: the shared multiply/restoring-divide unit blends left then right, and
// the result loads once the output is free; no new item is taken until then.
// Reset (synchronous, active high) clears all frame state and loads register
// defaults: rate ratio 1024, block 2048 frames, 8-bit mono unsigned, no auto-init.
`timescale 1ns / 1ps

module pcm_frame_resampler import pfr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   pfr_req_if.sink                req_bus,
   pfr_rsp_if.source              rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Configuration
   logic [RATIO_W-1:0] rate_ratio_ff, rate_ratio_in;
   logic               sixteen_bit_ff, sixteen_bit_in;
   logic               stereo_ff, stereo_in;
   logic               signed_data_ff, signed_data_in;
   logic               auto_init_ff, auto_init_in;
   logic [COUNT_W-1:0] block_frames_ff, block_frames_in;

   // Transfer state
   logic [FRAME_W-1:0] prev_frame_ff, prev_frame_in;
   logic [FRAME_W-1:0] cur_frame_ff, cur_frame_in;
   logic [FRAME_W-1:0] arrived_frame_ff, arrived_frame_in;
   logic               frame_ready_ff, frame_ready_in;
   logic               fetch_outstanding_ff, fetch_outstanding_in;
   logic [PHASE_W-1:0] phase_count_ff, phase_count_in;
   logic [COUNT_W-1:0] frames_left_ff, frames_left_in;
   logic               enabled_ff, enabled_in;
   logic               block_done_ff, block_done_in;

   // Tick bookkeeping
   logic [PHASE_W-1:0] ph_blend_ff, ph_blend;
   logic               pend_fetch_ff, pend_irq_ff, pend_irq16_ff, pend_running_ff;
   logic signed [SAMPLE_W-1:0] left_q_ff, right_q_ff;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_right_ff;
   logic                       rsp_sample_valid_ff, rsp_fetch_ff, rsp_irq_ff;
   logic                       rsp_irq16_ff, rsp_running_ff;

   ctrl_state_type     state_ff, state_in;
   blend_cmd_type      blend_cmd;
   blend_rsp_type      blend_rsp;

   logic               step_en, is_tick, slot_free;
   logic               load_now, load_tick, capture_left, capture_right;
   logic [RATIO_W-1:0] ratio_eff;
   logic               consume, stopped;
   logic [COUNT_W-1:0] count_dec;
   logic               fetch_now, irq_now, irq16_now;

   function automatic logic [FRAME_W-1:0] unpack_frame(input logic [FRAME_W-1:0] d,
                                                       input logic st, input logic s16,
                                                       input logic sgn);
      logic [FRAME_W-1:0] s;
      if (st) begin
         s = s16 ? d : {d[31:24], 8'h00, d[23:16], 8'h00};
      end else begin
         s = s16 ? {d[31:16], d[31:16]} : {d[31:24], 8'h00, d[31:24], 8'h00};
      end
      if (!sgn) s = s ^ SIGN_FLIP;
      return s;
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign step_en   = req_bus.valid && req_bus.ready;
   assign is_tick   = (req_bus.mode == MODE_TICK);
   assign ratio_eff = (rate_ratio_ff == '0) ? RATIO_W'(1) : rate_ratio_ff;
   assign count_dec = frames_left_ff - COUNT_W'(1);
   assign load_now  = step_en && !is_tick;

   // Frame state update on each transfer, then register writes
   always_comb begin
      rate_ratio_in        = rate_ratio_ff;
      sixteen_bit_in       = sixteen_bit_ff;
      stereo_in            = stereo_ff;
      signed_data_in       = signed_data_ff;
      auto_init_in         = auto_init_ff;
      block_frames_in      = block_frames_ff;
      prev_frame_in        = prev_frame_ff;
      cur_frame_in         = cur_frame_ff;
      arrived_frame_in     = arrived_frame_ff;
      frame_ready_in       = frame_ready_ff;
      fetch_outstanding_in = fetch_outstanding_ff;
      phase_count_in       = phase_count_ff;
      frames_left_in       = frames_left_ff;
      enabled_in           = enabled_ff;
      block_done_in        = block_done_ff;
      ph_blend             = phase_count_ff;
      consume              = 1'b0;
      stopped              = 1'b0;
      fetch_now            = 1'b0;
      irq_now              = 1'b0;
      irq16_now            = 1'b0;

      if (step_en) begin
         case (req_bus.mode)
            MODE_START, MODE_RESUME: begin
               if (req_bus.mode == MODE_START) frames_left_in = block_frames_ff;
               block_done_in = 1'b0;
               if (!enabled_ff) begin
                  enabled_in           = 1'b1;
                  prev_frame_in        = '0;
                  cur_frame_in         = '0;
                  arrived_frame_in     = '0;
                  frame_ready_in       = 1'b0;
                  phase_count_in       = '0;
                  fetch_outstanding_in = 1'b1;
                  fetch_now            = 1'b1;
               end
            end
            MODE_PAUSE: begin
               enabled_in           = 1'b0;
               prev_frame_in        = '0;
               cur_frame_in         = '0;
               arrived_frame_in     = '0;
               frame_ready_in       = 1'b0;
               fetch_outstanding_in = 1'b0;
               phase_count_in       = '0;
            end
            MODE_FRAME: begin
               // drop frames that arrive while stopped
               if (enabled_ff) begin
                  arrived_frame_in     = unpack_frame(req_bus.frame_data, stereo_ff,
                                                      sixteen_bit_ff, signed_data_ff);
                  frame_ready_in       = 1'b1;
                  fetch_outstanding_in = 1'b0;
               end
            end
            MODE_TICK: begin
               consume = frame_ready_ff && (phase_count_ff >= PHASE_W'(ratio_eff));
               if (consume) begin
                  prev_frame_in  = cur_frame_ff;
                  cur_frame_in   = arrived_frame_ff;
                  frame_ready_in = 1'b0;
                  ph_blend       = phase_count_ff - PHASE_W'(ratio_eff);
                  frames_left_in = count_dec;
                  if (count_dec == '0) begin
                     block_done_in = 1'b1;
                     irq_now       = 1'b1;
                     irq16_now     = sixteen_bit_ff;
                     if (auto_init_ff) begin
                        frames_left_in = block_frames_ff;
                     end else begin
                        // block end: stop and drop the format
                        enabled_in           = 1'b0;
                        prev_frame_in        = '0;
                        cur_frame_in         = '0;
                        arrived_frame_in     = '0;
                        frame_ready_in       = 1'b0;
                        fetch_outstanding_in = 1'b0;
                        ph_blend             = '0;
                        sixteen_bit_in       = 1'b0;
                        stereo_in            = 1'b0;
                        signed_data_in       = 1'b0;
                        stopped              = 1'b1;
                     end
                  end
                  if (!stopped && enabled_ff && !fetch_outstanding_ff) begin
                     fetch_outstanding_in = 1'b1;
                     fetch_now            = 1'b1;
                  end
               end
               phase_count_in = ph_blend + PHASE_STEP;
            end
            default: ;
         endcase
      end

      if (csr_write_enable) begin
         case (csr_index)
            REG_RATE_RATIO:   rate_ratio_in   = csr_write_data[RATIO_W-1:0];
            REG_SIXTEEN_BIT:  sixteen_bit_in  = csr_write_data[0];
            REG_STEREO:       stereo_in       = csr_write_data[0];
            REG_SIGNED_DATA:  signed_data_in  = csr_write_data[0];
            REG_AUTO_INIT:    auto_init_in    = csr_write_data[0];
            REG_BLOCK_FRAMES: block_frames_in = csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (step_en && is_tick) state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_LEFT;
         ST_LEFT:   if (blend_rsp.done) state_in = ST_RIGHT;
         ST_RIGHT:  if (blend_rsp.done) state_in = ST_DONE;
         ST_DONE:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_bus.ready   = 1'b0;
      blend_cmd.start = 1'b0;
      blend_cmd.a     = $signed(prev_frame_ff[SAMPLE_W-1:0]);
      blend_cmd.b     = $signed(cur_frame_ff[SAMPLE_W-1:0]);
      capture_left    = 1'b0;
      capture_right   = 1'b0;
      load_tick       = 1'b0;
      case (state_ff)
         ST_IDLE:   req_bus.ready = slot_free;
         ST_LAUNCH: blend_cmd.start = 1'b1;
         ST_LEFT: begin
            blend_cmd.a     = $signed(prev_frame_ff[FRAME_W-1:SAMPLE_W]);
            blend_cmd.b     = $signed(cur_frame_ff[FRAME_W-1:SAMPLE_W]);
            blend_cmd.start = blend_rsp.done;
            capture_left    = blend_rsp.done;
         end
         ST_RIGHT:  capture_right = blend_rsp.done;
         ST_DONE:   load_tick = slot_free;
         default: ;
      endcase
   end

   pfr_blend_unit u_blend (
      .clock (clock),
      .reset (reset),
      .cmd   (blend_cmd),
      .ratio (ratio_eff),
      .phase (ph_blend_ff),
      .rsp   (blend_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_now || load_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ratio_ff        <= RATIO_RESET;
         sixteen_bit_ff       <= 1'b0;
         stereo_ff            <= 1'b0;
         signed_data_ff       <= 1'b0;
         auto_init_ff         <= 1'b0;
         block_frames_ff      <= BLOCK_RESET;
         prev_frame_ff        <= '0;
         cur_frame_ff         <= '0;
         arrived_frame_ff     <= '0;
         frame_ready_ff       <= 1'b0;
         fetch_outstanding_ff <= 1'b0;
         phase_count_ff       <= '0;
         frames_left_ff       <= '0;
         enabled_ff           <= 1'b0;
         block_done_ff        <= 1'b0;
         state_ff             <= ST_IDLE;
         rsp_valid_ff         <= 1'b0;
      end else begin
         rate_ratio_ff        <= rate_ratio_in;
         sixteen_bit_ff       <= sixteen_bit_in;
         stereo_ff            <= stereo_in;
         signed_data_ff       <= signed_data_in;
         auto_init_ff         <= auto_init_in;
         block_frames_ff      <= block_frames_in;
         prev_frame_ff        <= prev_frame_in;
         cur_frame_ff         <= cur_frame_in;
         arrived_frame_ff     <= arrived_frame_in;
         frame_ready_ff       <= frame_ready_in;
         fetch_outstanding_ff <= fetch_outstanding_in;
         phase_count_ff       <= phase_count_in;
         frames_left_ff       <= frames_left_in;
         enabled_ff           <= enabled_in;
         block_done_ff        <= block_done_in;
         state_ff             <= state_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (step_en && is_tick) begin
         ph_blend_ff     <= ph_blend;
         pend_fetch_ff   <= fetch_now;
         pend_irq_ff     <= irq_now;
         pend_irq16_ff   <= irq16_now;
         pend_running_ff <= enabled_in;
      end
      if (capture_left)  left_q_ff  <= blend_rsp.q;
      if (capture_right) right_q_ff <= blend_rsp.q;
      if (load_now) begin
         rsp_left_ff         <= '0;
         rsp_right_ff        <= '0;
         rsp_sample_valid_ff <= 1'b0;
         rsp_fetch_ff        <= fetch_now;
         rsp_irq_ff          <= 1'b0;
         rsp_irq16_ff        <= 1'b0;
         rsp_running_ff      <= enabled_in;
      end else if (load_tick) begin
         rsp_left_ff         <= left_q_ff;
         rsp_right_ff        <= right_q_ff;
         rsp_sample_valid_ff <= 1'b1;
         rsp_fetch_ff        <= pend_fetch_ff;
         rsp_irq_ff          <= pend_irq_ff;
         rsp_irq16_ff        <= pend_irq16_ff;
         rsp_running_ff      <= pend_running_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.left          = rsp_left_ff;
   assign rsp_bus.right         = rsp_right_ff;
   assign rsp_bus.sample_valid  = rsp_sample_valid_ff;
   assign rsp_bus.fetch_request = rsp_fetch_ff;
   assign rsp_bus.block_irq     = rsp_irq_ff;
   assign rsp_bus.irq_is_16bit  = rsp_irq16_ff;
   assign rsp_bus.running       = rsp_running_ff;

   a_tick_launches: assert property (@(posedge clock) disable iff (reset)
      (step_en && is_tick) |=> (state_ff == ST_LAUNCH))
      else $error("output tick did not start the blend sequence");

   a_plain_result: assert property (@(posedge clock) disable iff (reset)
      (step_en && !is_tick) |=> (rsp_valid_ff && !rsp_sample_valid_ff))
      else $error("non-tick transfer did not produce a result");

   a_idle_pipeline: assert property (@(posedge clock) disable iff (reset)
      (frame_ready_ff || fetch_outstanding_ff) |-> enabled_ff)
      else $error("frame pipeline active while transfer disabled");

endmodule

@@ verif/tb_pcm_frame_resampler.sv @@
// Testbench for pcm_frame_resampler: directed and random playback traffic,
// checked against a cycle-free predictor held in a small scoreboard class.
// Depends on pfr_pkg, pfr_req_if and pfr_rsp_if from the rtl folder.
`timescale 1ns / 1ps

module tb_pcm_frame_resampler;
   import pfr_pkg::*;

   localparam int HALF_PERIOD      = 6;
   localparam int STALL_LIMIT      = 5000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 250;

   // Modes the block treats as no-ops, and a register index it ignores.
   localparam logic [MODE_W-1:0]      MODE_SPARE_A = 3'd5;
   localparam logic [MODE_W-1:0]      MODE_SPARE_B = 3'd6;
   localparam logic [MODE_W-1:0]      MODE_SPARE_C = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE    = 3'd6;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       sample_valid;
      logic                       fetch_request;
      logic                       block_irq;
      logic                       irq_is_16bit;
      logic                       running;
   } playback_result_type;

   class resampler_scoreboard;
      logic [RATIO_W-1:0] rate_ratio;
      logic               sixteen_bit, stereo, signed_data, auto_init;
      logic [COUNT_W-1:0] block_frames;
      logic [FRAME_W-1:0] prev_frame, cur_frame, arrived_frame;
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] frames_left;
      logic               frame_ready, fetch_pending, enabled, block_done;
      playback_result_type pending_outputs[$];
      int                 failures;

      function new();
         rate_ratio   = RATIO_RESET;
         sixteen_bit  = 1'b0;
         stereo       = 1'b0;
         signed_data  = 1'b0;
         auto_init    = 1'b0;
         block_frames = BLOCK_RESET;
         clear_pipeline();
         frames_left  = '0;
         enabled      = 1'b0;
         block_done   = 1'b0;
         failures     = 0;
      endfunction

      function void clear_pipeline();
         prev_frame    = '0;
         cur_frame     = '0;
         arrived_frame = '0;
         frame_ready   = 1'b0;
         fetch_pending = 1'b0;
         phase         = '0;
      endfunction

      function bit open_transfer();
         if (enabled) return 1'b0;
         enabled = 1'b1;
         clear_pipeline();
         fetch_pending = 1'b1;
         return 1'b1;
      endfunction

      function void close_transfer(bit keep_format);
         enabled = 1'b0;
         clear_pipeline();
         if (!keep_format) begin
            sixteen_bit = 1'b0;
            stereo      = 1'b0;
            signed_data = 1'b0;
         end
      endfunction

      function longint half(logic [FRAME_W-1:0] w, bit upper);
         logic signed [SAMPLE_W-1:0] h;
         h = upper ? w[31:16] : w[15:0];
         return h;
      endfunction

      // Signed blend; the quotient truncates toward zero, then wraps to 16 bits.
      function logic [SAMPLE_W-1:0] blend(longint a, longint b, longint ratio, longint ph);
         longint q;
         q = (a * (ratio - ph) + b * ph) / ratio;
         return q[SAMPLE_W-1:0];
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_RATE_RATIO:   rate_ratio   = value[RATIO_W-1:0];
            REG_SIXTEEN_BIT:  sixteen_bit  = value[0];
            REG_STEREO:       stereo       = value[0];
            REG_SIGNED_DATA:  signed_data  = value[0];
            REG_AUTO_INIT:    auto_init    = value[0];
            REG_BLOCK_FRAMES: block_frames = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void predict_output(logic [MODE_W-1:0] mode, logic [FRAME_W-1:0] word);
         playback_result_type r;
         logic [FRAME_W-1:0] s;
         logic [PHASE_W-1:0] ratio;
         bit                 stopped;
         r = '0;
         case (mode)
            MODE_START: begin
               frames_left     = block_frames;
               block_done      = 1'b0;
               r.fetch_request = open_transfer();
            end
            MODE_RESUME: begin
               block_done      = 1'b0;
               r.fetch_request = open_transfer();
            end
            MODE_PAUSE: close_transfer(1'b1);
            MODE_FRAME: begin
               if (enabled) begin
                  if (stereo)
                     s = sixteen_bit ? word
                                     : ((word & 32'hFF00_0000) | ((word >> 8) & 32'h0000_FF00));
                  else
                     s = sixteen_bit ? ((word & 32'hFFFF_0000) | (word >> 16))
                                     : ((word & 32'hFF00_0000) | ((word >> 16) & 32'h0000_FF00));
                  if (!signed_data) s = s ^ SIGN_FLIP;
                  arrived_frame = s;
                  frame_ready   = 1'b1;
                  fetch_pending = 1'b0;
               end
            end
            MODE_TICK: begin
               ratio = (rate_ratio == '0) ? PHASE_W'(1) : PHASE_W'(rate_ratio);
               if (phase >= ratio && frame_ready) begin
                  stopped     = 1'b0;
                  prev_frame  = cur_frame;
                  cur_frame   = arrived_frame;
                  frame_ready = 1'b0;
                  phase       = phase - ratio;
                  frames_left = frames_left - 1'b1;
                  if (frames_left == '0) begin
                     block_done     = 1'b1;
                     r.block_irq    = 1'b1;
                     r.irq_is_16bit = sixteen_bit;
                     if (auto_init) begin
                        frames_left = block_frames;
                     end else begin
                        close_transfer(1'b0);
                        stopped = 1'b1;
                     end
                  end
                  if (!stopped && enabled && !fetch_pending) begin
                     fetch_pending   = 1'b1;
                     r.fetch_request = 1'b1;
                  end
               end
               r.left  = blend(half(prev_frame, 1'b0), half(cur_frame, 1'b0), ratio, phase);
               r.right = blend(half(prev_frame, 1'b1), half(cur_frame, 1'b1), ratio, phase);
               r.sample_valid = 1'b1;
               phase = phase + PHASE_STEP;
            end
            default: ;
         endcase
         r.running = enabled;
         pending_outputs.push_back(r);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_output(playback_result_type got);
         playback_result_type want;
         if (pending_outputs.size() == 0) begin
            failures++;
            $display("%0t: output with no prediction pending, left %0d right %0d",
                     $time, got.left, got.right);
            return;
         end
         want = pending_outputs.pop_front();
         compare_field("left", want.left, got.left);
         compare_field("right", want.right, got.right);
         compare_field("sample_valid", want.sample_valid, got.sample_valid);
         compare_field("fetch_request", want.fetch_request, got.fetch_request);
         compare_field("block_irq", want.block_irq, got.block_irq);
         compare_field("irq_is_16bit", want.irq_is_16bit, got.irq_is_16bit);
         compare_field("running", want.running, got.running);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   pfr_req_if req_bus ();
   pfr_rsp_if rsp_bus ();

   resampler_scoreboard sb = new();

   bit tx_idle_on      = 1'b1;
   bit rx_idle_on      = 1'b1;
   bit long_hold_armed = 1'b0;
   int quiet_cycles    = 0;

   pcm_frame_resampler u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   always @(posedge clock) begin : monitor
      playback_result_type got;
      if (!reset) begin
         if (csr_write_enable) sb.write_reg(csr_index, csr_write_data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.left          = rsp_bus.left;
            got.right         = rsp_bus.right;
            got.sample_valid  = rsp_bus.sample_valid;
            got.fetch_request = rsp_bus.fetch_request;
            got.block_irq     = rsp_bus.block_irq;
            got.irq_is_16bit  = rsp_bus.irq_is_16bit;
            got.running       = rsp_bus.running;
            sb.check_output(got);
         end
         if (req_bus.valid && req_bus.ready) sb.predict_output(req_bus.mode, req_bus.frame_data);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Result side: short random stalls, plus one long hold when armed.
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [FRAME_W-1:0] word);
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.frame_data <= word;
      do @(posedge clock); while (!req_bus.ready);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Hold the sender until every predicted output has been seen; the extra
   // edge first lets the monitor note the last transfer.
   task automatic drain_outputs();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_outputs.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [RATIO_W-1:0] ratio, input bit wide,
                                input bit two_ch, input bit signed_fmt, input bit reload,
                                input logic [COUNT_W-1:0] frames);
      logic [CSR_DATA_W-1:0] value [0:REG_SPARE];
      value[REG_RATE_RATIO]   = ratio;
      value[REG_SIXTEEN_BIT]  = CSR_DATA_W'(wide);
      value[REG_STEREO]       = CSR_DATA_W'(two_ch);
      value[REG_SIGNED_DATA]  = CSR_DATA_W'(signed_fmt);
      value[REG_AUTO_INIT]    = CSR_DATA_W'(reload);
      value[REG_BLOCK_FRAMES] = CSR_DATA_W'(frames);
      value[REG_SPARE]        = CSR_DATA_W'($urandom);
      for (int i = 0; i <= REG_SPARE; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_INDEX_W'(i);
         csr_write_data   <= value[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_settings(input logic [RATIO_W-1:0] ratio,
                                  input logic [COUNT_W-1:0] frames);
      load_settings(ratio, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), frames);
   endtask

   // Mostly start/frame/tick traffic that follows the fetch requests, with
   // some pauses, spare modes and surplus frames mixed in.
   task automatic run_phase(input int count, input int hold_at);
      logic [MODE_W-1:0]  mode;
      logic [FRAME_W-1:0] word;
      int                 roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (!sb.enabled && roll < 60)
            mode = (roll < 40) ? MODE_START : MODE_RESUME;
         else if (roll < 3)
            mode = MODE_PAUSE;
         else if (roll < 5)
            mode = MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
         else if (roll < 7)
            mode = (roll == 5) ? MODE_START : MODE_RESUME;
         else if (sb.fetch_pending ? roll < 80 : roll < 15)
            mode = MODE_FRAME;
         else
            mode = MODE_TICK;
         case ($urandom_range(0, 7))
            0:       word = '0;
            1:       word = '1;
            2:       word = SIGN_FLIP;
            3:       word = ~SIGN_FLIP;
            default: word = $urandom;
         endcase
         send_item(mode, word);
         if (n == hold_at) long_hold_armed = 1'b1;
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= MODE_START;
      req_bus.frame_data <= '0;
      csr_write_enable   <= 1'b0;
      csr_index          <= REG_RATE_RATIO;
      csr_write_data     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero ratio (acts as one), two-frame block, 16-bit stereo signed.
      load_settings('0, 1'b1, 1'b1, 1'b1, 1'b0, 17'd2);
      send_item(MODE_TICK, '0);              // tick while stopped
      send_item(MODE_FRAME, '1);             // frame while stopped is dropped
      send_item(MODE_SPARE_A, '1);
      send_item(MODE_SPARE_B, '0);
      send_item(MODE_SPARE_C, '1);
      send_item(MODE_START, '0);
      send_item(MODE_START, '0);             // start while running reloads the count
      send_item(MODE_FRAME, 32'h7FFF_8000);
      send_item(MODE_FRAME, 32'h8000_7FFF);  // overwrite an unconsumed frame
      send_item(MODE_TICK, '0);
      send_item(MODE_TICK, '0);              // consume, extrapolate far past ratio
      send_item(MODE_TICK, '0);              // underrun
      send_item(MODE_FRAME, '1);
      send_item(MODE_TICK, '0);              // block end without auto-init
      send_item(MODE_TICK, '0);
      send_item(MODE_RESUME, '0);            // count left at zero
      send_item(MODE_FRAME, '0);
      send_item(MODE_TICK, '0);              // phase below ratio: nothing consumed, count stays
      send_item(MODE_PAUSE, '0);
      send_item(MODE_FRAME, 32'h1234_5678);
      send_item(MODE_TICK, '0);
      send_item(MODE_RESUME, '0);
      drain_outputs();

      load_settings(24'd1024, 1'b0, 1'b0, 1'b0, 1'b1, 17'd4);
      run_phase(100, -1);
      drain_outputs();

      load_settings(24'd1, 1'b1, 1'b1, 1'b1, 1'b0, 17'd3);
      run_phase(100, -1);
      drain_outputs();

      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      load_settings(24'hFF_FFFF, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b1, 17'h1_0000);
      run_phase(100, -1);
      drain_outputs();

      // Long hold on the result side while items keep coming.
      random_settings(RATIO_W'($urandom_range(1024, 4096)), COUNT_W'($urandom_range(1, 8)));
      run_phase(100, 20);
      drain_outputs();

      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      random_settings(24'd512, '0);
      run_phase(100, -1);
      drain_outputs();

      random_settings(RATIO_W'($urandom_range(1, 8192)), COUNT_W'($urandom_range(1, 6)));
      run_phase(50, -1);
      drain_outputs();
      run_phase(50, -1);
      drain_outputs();

      random_settings(RATIO_W'($urandom_range(1, 8192)), COUNT_W'($urandom_range(1, 6)));
      run_phase(100, -1);
      drain_outputs();

      random_settings(RATIO_W'($urandom_range(1, 3000)), COUNT_W'($urandom_range(1, 6)));
      run_phase(100, -1);
      drain_outputs();

      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      random_settings(RATIO_W'($urandom_range(1, 8192)), COUNT_W'($urandom_range(1, 6)));
      run_phase(100, -1);
      drain_outputs();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending_outputs.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
